// File: rtl/core/ps2_mouse_packet_cursor_tracker_defines.svh
// ----------------------------------------------------------------------------
// ps2 mouse cursor tracker assertion macros
// shorthand for clocked implications with an async active-low reset
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_DEFINES_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_DEFINES_SVH

// same-cycle implication
`define PMT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("ps2 cursor tracker check failed");

// next-cycle implication
`define PMT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("ps2 cursor tracker check failed");

`endif

// File: rtl/core/ps2mct_pkg.sv
// ----------------------------------------------------------------------------
// ps2mct_pkg
// shared constants, types and the delta decode for the cursor tracker
// ----------------------------------------------------------------------------
package ps2mct_pkg;

	localparam int MAX_SCREEN = 4096;
	localparam int POS_W      = $clog2(MAX_SCREEN);
	localparam int CFG_W      = 13;
	localparam int DELTA_W    = 10;
	localparam int SUM_W      = ((POS_W > DELTA_W) ? POS_W : DELTA_W) + 2;
	localparam int OVF_STEP   = 255;

	// register indexes
	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(1024);
	localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(768);

	// header bit positions
	localparam int HDR_LEFT   = 0;
	localparam int HDR_RIGHT  = 1;
	localparam int HDR_MIDDLE = 2;
	localparam int HDR_XSIGN  = 4;
	localparam int HDR_YSIGN  = 5;
	localparam int HDR_XOVF   = 6;
	localparam int HDR_YOVF   = 7;

	typedef enum logic [2:0] {
		SLOT_HDR = 3'b001,
		SLOT_X   = 3'b010,
		SLOT_Y   = 3'b100
	} slot_t;

	typedef struct packed {
		logic       done;
		logic [7:0] header;
		logic [7:0] x_byte;
		logic [7:0] y_byte;
	} frame_pkt_t;

	// 9-bit delta plus overflow extension in the sign direction
	function automatic logic signed [DELTA_W-1:0] mouse_delta(
		input logic [7:0] low,
		input logic       neg,
		input logic       ovf
	);
		logic signed [DELTA_W-1:0] d;
		d = DELTA_W'($signed({neg, low}));
		if (ovf) begin
			if (neg)
				d = d - $signed(DELTA_W'(OVF_STEP));
			else
				d = d + $signed(DELTA_W'(OVF_STEP));
		end
		return d;
	endfunction

endpackage

// File: rtl/core/ps2_mouse_packet_cursor_tracker.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker
// ps2 mouse three-byte packet decoder with clamped cursor position
// ----------------------------------------------------------------------------
// Takes one mouse byte per word on the input channel. The first byte after
// reset is dropped; the rest are framed as header, x delta, y delta. When the
// y byte arrives the cursor moves by +dx and -dy (screen y grows downward),
// each axis clamped to 0..size-1, the buttons are latched from the header and
// one word goes out. Header and x bytes produce no output word. A new byte can
// be taken every cycle while the output side keeps up: one input register stage
// feeds the framing and axis logic, whose result lands in the output register,
// so the word for a y byte passes the input register and then the output
// register, and throughput is one byte per cycle. The output register also
// holds the tracked cursor state, so a stalled output stalls only a y byte;
// header and x bytes still pass. Screen width and height are written on the
// cfg port (index 0 width, index 1 height); a size of 0 acts as 1 and a size
// above 4096 acts as 4096. A new size takes effect on the next completed
// packet.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker (
	input  logic                                clk,
	input  logic                                arst_n,
	// byte input
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          rx_byte,
	// cursor output
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ps2mct_pkg::POS_W-1:0]        cursor_x,
	output logic [ps2mct_pkg::POS_W-1:0]        cursor_y,
	output logic                                left_pressed,
	output logic                                middle_pressed,
	output logic                                right_pressed,
	// config writes
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [ps2mct_pkg::CFG_W-1:0]        cfg_data
);

	// screen size registers
	logic [ps2mct_pkg::CFG_W-1:0] width_q;
	logic [ps2mct_pkg::CFG_W-1:0] height_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// output stage, doubles as cursor and button state
	logic                         out_valid_q;
	logic [ps2mct_pkg::POS_W-1:0] pos_x_q;
	logic [ps2mct_pkg::POS_W-1:0] pos_y_q;
	logic [2:0]                   buttons_q;

	ps2mct_pkg::frame_pkt_t               pkt;
	logic                                 out_free;
	logic                                 take;
	logic signed [ps2mct_pkg::DELTA_W-1:0] dx;
	logic signed [ps2mct_pkg::DELTA_W-1:0] dy;
	logic [ps2mct_pkg::POS_W-1:0]         pos_x_nxt;
	logic [ps2mct_pkg::POS_W-1:0]         pos_y_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ps2mct_pkg::WIDTH_RST;
			height_q <= ps2mct_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ps2mct_pkg::CFG_WIDTH:  width_q  <= cfg_data;
				ps2mct_pkg::CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// output slot is free when empty or being drained this cycle
	assign out_free = !out_valid_q || out_ready;
	// the staged byte moves on unless it completes a packet and output is blocked
	assign take     = valid_s1 && (!pkt.done || out_free);
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			byte_s1 <= rx_byte;
	end

	ps2mct_frame u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_vld (valid_s1),
		.byte_in  (byte_s1),
		.take     (take),
		.pkt      (pkt)
	);

	// deltas from header sign and overflow bits
	assign dx = ps2mct_pkg::mouse_delta(pkt.x_byte,
		pkt.header[ps2mct_pkg::HDR_XSIGN], pkt.header[ps2mct_pkg::HDR_XOVF]);
	assign dy = ps2mct_pkg::mouse_delta(pkt.y_byte,
		pkt.header[ps2mct_pkg::HDR_YSIGN], pkt.header[ps2mct_pkg::HDR_YOVF]);

	ps2mct_axis u_axis_x (
		.pos      (pos_x_q),
		.delta    (dx),
		.sub      (1'b0),
		.size     (width_q),
		.pos_next (pos_x_nxt)
	);

	// y is subtracted, screen y grows downward
	ps2mct_axis u_axis_y (
		.pos      (pos_y_q),
		.delta    (dy),
		.sub      (1'b1),
		.size     (height_q),
		.pos_next (pos_y_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			buttons_q   <= '0;
		end else begin
			if (out_free)
				out_valid_q <= take && pkt.done;
			if (take && pkt.done) begin
				pos_x_q   <= pos_x_nxt;
				pos_y_q   <= pos_y_nxt;
				buttons_q <= {pkt.header[ps2mct_pkg::HDR_MIDDLE],
					pkt.header[ps2mct_pkg::HDR_RIGHT],
					pkt.header[ps2mct_pkg::HDR_LEFT]};
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign cursor_x       = pos_x_q;
	assign cursor_y       = pos_y_q;
	assign left_pressed   = buttons_q[0];
	assign right_pressed  = buttons_q[1];
	assign middle_pressed = buttons_q[2];

endmodule

// File: rtl/core/ps2mct_axis.sv
// ----------------------------------------------------------------------------
// ps2mct_axis
// one cursor axis: apply a delta and clamp to the screen size
// ----------------------------------------------------------------------------
module ps2mct_axis (
	input  logic [ps2mct_pkg::POS_W-1:0]          pos,
	input  logic signed [ps2mct_pkg::DELTA_W-1:0] delta,
	input  logic                                  sub,
	input  logic [ps2mct_pkg::CFG_W-1:0]          size,
	output logic [ps2mct_pkg::POS_W-1:0]          pos_next
);

	logic signed [ps2mct_pkg::SUM_W-1:0] dext;
	logic signed [ps2mct_pkg::SUM_W-1:0] sum;
	logic signed [ps2mct_pkg::SUM_W-1:0] top_ext;
	logic [ps2mct_pkg::POS_W-1:0]        top;

	// largest legal coordinate, zero size acts as one
	always_comb begin
		if (size == '0)
			top = '0;
		else if (size > ps2mct_pkg::CFG_W'(ps2mct_pkg::MAX_SCREEN))
			top = ps2mct_pkg::POS_W'(ps2mct_pkg::MAX_SCREEN - 1);
		else
			top = ps2mct_pkg::POS_W'(size - ps2mct_pkg::CFG_W'(1));
	end

	always_comb begin
		dext    = ps2mct_pkg::SUM_W'(delta);
		top_ext = $signed({{(ps2mct_pkg::SUM_W-ps2mct_pkg::POS_W){1'b0}}, top});
		sum     = $signed({{(ps2mct_pkg::SUM_W-ps2mct_pkg::POS_W){1'b0}}, pos})
			+ (sub ? -dext : dext);
		if (sum < 0)
			pos_next = '0;
		else if (sum > top_ext)
			pos_next = top;
		else
			pos_next = sum[ps2mct_pkg::POS_W-1:0];
	end

endmodule

// File: rtl/core/ps2mct_frame.sv
// ----------------------------------------------------------------------------
// ps2mct_frame
// byte framing: drops the first byte, then tracks header / x / y slots
// ----------------------------------------------------------------------------
module ps2mct_frame (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_vld,
	input  logic [7:0]             byte_in,
	input  logic                   take,
	output ps2mct_pkg::frame_pkt_t pkt
);

	logic              skip_q;
	ps2mct_pkg::slot_t slot_q;
	logic [7:0]        header_q;
	logic [7:0]        x_byte_q;

	always_comb begin
		pkt.done   = byte_vld && !skip_q && (slot_q == ps2mct_pkg::SLOT_Y);
		pkt.header = header_q;
		pkt.x_byte = x_byte_q;
		pkt.y_byte = byte_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= 1'b1;
			slot_q <= ps2mct_pkg::SLOT_HDR;
		end else if (take) begin
			if (skip_q) begin
				skip_q <= 1'b0;
			end else begin
				case (slot_q)
					ps2mct_pkg::SLOT_X: slot_q <= ps2mct_pkg::SLOT_Y;
					ps2mct_pkg::SLOT_Y: slot_q <= ps2mct_pkg::SLOT_HDR;
					default:            slot_q <= ps2mct_pkg::SLOT_X;
				endcase
			end
		end
	end

	// payload bytes, no reset
	always_ff @(posedge clk) begin
		if (take && !skip_q) begin
			case (slot_q)
				ps2mct_pkg::SLOT_X: x_byte_q <= byte_in;
				ps2mct_pkg::SLOT_Y: ;
				default:            header_q <= byte_in;
			endcase
		end
	end

endmodule

// File: rtl/core/ps2mct_checker.sv
// ----------------------------------------------------------------------------
// ps2mct_checker
// port-level checks on the cursor tracker, bound to the top level
// ----------------------------------------------------------------------------
`include "ps2_mouse_packet_cursor_tracker_defines.svh"

module ps2mct_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [ps2mct_pkg::POS_W-1:0] cursor_x,
	input logic [ps2mct_pkg::POS_W-1:0] cursor_y,
	input logic                         left_pressed,
	input logic                         middle_pressed,
	input logic                         right_pressed
);

	// stalled output word holds
	`PMT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(cursor_x) && $stable(cursor_y))

	// with the output empty the input side never stalls
	`PMT_ASSERT_NOW(a_in_free, clk, arst_n, !out_valid, in_ready)

	// cursor only moves together with a new output word
	`PMT_ASSERT_NOW(a_pos_moves, clk, arst_n, !$stable(cursor_x) || !$stable(cursor_y), out_valid)

	// buttons only change together with a new output word
	`PMT_ASSERT_NOW(a_btn_moves, clk, arst_n, !$stable({left_pressed, middle_pressed, right_pressed}), out_valid)

endmodule

bind ps2_mouse_packet_cursor_tracker ps2mct_checker u_ps2mct_checker (.*);
